// ===== hdl/fixed_page_free_list_allocator_defines.svh =====
// Assertion macros for the fixed-page free-list allocator.
// Depends on nothing; the including module supplies signals named clk and rst.
`ifndef FIXED_PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising clk edge outside reset.
`define FPFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising clk edge, reset included.
`define FPFL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPFL_ASSERT(lbl, prop, msg)
`define FPFL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/fpfl_pkg.sv =====
// Shared types and constants of the fixed-page free-list allocator.
// Depends on nothing; used by the channel interfaces and the top-level module.
package fpfl_pkg;

  localparam int NUM_PAGES = 256;
  localparam int PAGE_W    = 8;
  localparam int CNT_W     = 9;
  localparam int REQ_W     = 17;
  localparam int CFG_W     = 17;

  localparam logic [CNT_W-1:0] PAGE_CAP      = CNT_W'(NUM_PAGES < 256 ? NUM_PAGES : 256);
  localparam logic [REQ_W-1:0] MIN_PAGE_SIZE = REQ_W'(8);

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_REINIT  = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_OUTSIDE  = 2'd2,
    ST_ALL_FREE = 2'd3
  } status_t;

  typedef enum logic {
    REG_PAGE_SIZE    = 1'b0,
    REG_PAGES_IN_USE = 1'b1
  } reg_index_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

// ===== hdl/fpfl_ifs.sv =====
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on fpfl_pkg for field widths.
interface fpfl_req_if import fpfl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [REQ_W-1:0] request_bytes;
  logic [PAGE_W-1:0] page_index;

  modport source (output valid, opcode, request_bytes, page_index, input ready);
  modport sink   (input valid, opcode, request_bytes, page_index, output ready);
endinterface

interface fpfl_rsp_if import fpfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [PAGE_W-1:0] granted_page;
  logic [CNT_W-1:0]  free_pages;

  modport source (output valid, status, granted_page, free_pages, input ready);
  modport sink   (input valid, status, granted_page, free_pages, output ready);
endinterface

// ===== hdl/fpfl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module fpfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fixed_page_free_list_allocator.sv =====
// Top level of the fixed-page free-list allocator.
// Depends on fpfl_pkg, the channel interfaces in fpfl_ifs.sv and fpfl_ram.

// The allocator hands out equal pages of a region by page index. Each request
// transaction carries an opcode: acquire pops the most recently released page,
// or else the next never-issued page in ascending order; release pushes a page
// back; reinitialize frees every page. Every request produces exactly one
// response transaction with a status, the granted page (zero unless an acquire
// succeeded) and the free page count after the request. An acquire is refused
// when the request exceeds the page size (values below 8 act as 8) or no page
// is free; a release of a page at or above the page count, or while every page
// is already free, is refused and flagged. Double releases are not detected.
// Each request is handled in an accept cycle, which reads the link memory at
// the current stack head, and then an execute cycle, which updates the state
// and loads the response register; no new request is taken during the execute
// cycle. The link memory is not cleared after reset; only links written by
// releases are ever followed, so no clearing pass is needed. Configuration
// writes (page_size, pages_in_use) must be made while the block is idle; a new
// page count applies at once to bounds checks but the free list is rebuilt
// only by a reinitialize.
`include "fixed_page_free_list_allocator_defines.svh"

module fixed_page_free_list_allocator import fpfl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             write_enable,
  input  logic             reg_index,
  input  logic [CFG_W-1:0] write_data,
  fpfl_req_if.sink         req_ch,
  fpfl_rsp_if.source       rsp_ch
);

  // Configuration registers.
  logic [REQ_W-1:0] page_size;
  logic [CNT_W-1:0] pages_in_use;

  // Allocator state. The release stack depth also tells whether the stack is
  // empty.
  logic [PAGE_W-1:0] stack_head, stack_head_next;
  logic [CNT_W-1:0]  stacked, stacked_next;
  logic [CNT_W-1:0]  fresh_mark, fresh_mark_next;
  logic [CNT_W-1:0]  free_count, free_count_next;

  // Captured request.
  opcode_t           op;
  logic [REQ_W-1:0]  req_bytes;
  logic [PAGE_W-1:0] req_page;

  // Response register.
  logic              rsp_valid;
  status_t           rsp_status, status_next;
  logic [PAGE_W-1:0] rsp_grant, grant_next;
  logic [CNT_W-1:0]  rsp_free;

  state_t state, state_next;

  logic              req_fire;
  logic              exec;
  logic              link_we;
  logic [PAGE_W-1:0] link_wdata;
  logic [PAGE_W-1:0] link_rdata;
  logic [CNT_W-1:0]  eff_pages;
  logic [REQ_W-1:0]  eff_page_size;
  logic              from_stack;
  logic              from_fresh;

  assign req_fire = req_ch.valid && req_ch.ready;
  assign exec     = (state == S_EXEC);

  // ---------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      page_size    <= MIN_PAGE_SIZE;
      pages_in_use <= CNT_W'(256);
    end else if (write_enable) begin
      unique case (reg_index_t'(reg_index))
        REG_PAGE_SIZE:    page_size    <= write_data;
        REG_PAGES_IN_USE: pages_in_use <= write_data[CNT_W-1:0];
      endcase
    end
  end

  // Effective page count is clamped to 1 .. PAGE_CAP.
  always_comb begin
    if (pages_in_use == '0) begin
      eff_pages = CNT_W'(1);
    end else if (pages_in_use > PAGE_CAP) begin
      eff_pages = PAGE_CAP;
    end else begin
      eff_pages = pages_in_use;
    end
  end

  assign eff_page_size = (page_size < MIN_PAGE_SIZE) ? MIN_PAGE_SIZE : page_size;

  // ---------------------------------------------------------------------
  // Link memory. The read address is always the stack head, which only moves
  // in the execute cycle, so the data read during the accept cycle is the link
  // of the current head when the execute cycle needs it.
  // ---------------------------------------------------------------------
  fpfl_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (req_page),
    .wdata (link_wdata),
    .raddr (stack_head),
    .rdata (link_rdata)
  );

  // ---------------------------------------------------------------------
  // Control: idle until a transaction is accepted, then execute, then idle again.
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_fire) state_next = S_EXEC;
      S_EXEC: state_next = S_IDLE;
    endcase
  end

  // A new request is taken only when the response register will be free by
  // the execute cycle.
  always_comb begin
    unique case (state)
      S_IDLE:  req_ch.ready = !rsp_valid || rsp_ch.ready;
      S_EXEC:  req_ch.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The opcode starts out as the unused one so that the decode below always
  // sees a defined value, even before the first transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_NONE;
    end else if (req_fire) begin
      op        <= opcode_t'(req_ch.opcode);
      req_bytes <= req_ch.request_bytes;
      req_page  <= req_ch.page_index;
    end
  end

  // ---------------------------------------------------------------------
  // Execute: decide the outcome and the next allocator state.
  // ---------------------------------------------------------------------
  assign from_stack = (stacked != '0);
  assign from_fresh = !from_stack && (fresh_mark < eff_pages);

  always_comb begin
    stack_head_next = stack_head;
    stacked_next    = stacked;
    fresh_mark_next = fresh_mark;
    free_count_next = free_count;
    status_next     = ST_OK;
    grant_next      = '0;
    link_we         = 1'b0;
    // A push onto an empty stack terminates the list with page zero.
    link_wdata      = from_stack ? stack_head : '0;

    unique case (op)
      OP_ACQUIRE: begin
        if (req_bytes > eff_page_size || free_count == '0 ||
            (!from_stack && !from_fresh)) begin
          status_next = ST_REFUSED;
        end else if (from_stack) begin
          grant_next      = stack_head;
          stacked_next    = stacked - CNT_W'(1);
          free_count_next = free_count - CNT_W'(1);
          // The head stays put when the last stacked page leaves.
          if (stacked != CNT_W'(1)) begin
            stack_head_next = link_rdata;
          end
        end else begin
          grant_next      = fresh_mark[PAGE_W-1:0];
          fresh_mark_next = fresh_mark + CNT_W'(1);
          free_count_next = free_count - CNT_W'(1);
        end
      end
      OP_RELEASE: begin
        if ({1'b0, req_page} >= eff_pages) begin
          status_next = ST_OUTSIDE;
        end else if (free_count >= eff_pages) begin
          status_next = ST_ALL_FREE;
        end else begin
          link_we         = exec;
          stack_head_next = req_page;
          stacked_next    = stacked + CNT_W'(1);
          free_count_next = free_count + CNT_W'(1);
        end
      end
      OP_REINIT: begin
        free_count_next = eff_pages;
        fresh_mark_next = '0;
        stack_head_next = '0;
        stacked_next    = '0;
      end
      OP_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_head <= '0;
      stacked    <= '0;
      fresh_mark <= '0;
      free_count <= PAGE_CAP;
    end else if (exec) begin
      stack_head <= stack_head_next;
      stacked    <= stacked_next;
      fresh_mark <= fresh_mark_next;
      free_count <= free_count_next;
    end
  end

  // ---------------------------------------------------------------------
  // Response register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ch.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rsp_status <= status_next;
      rsp_grant  <= grant_next;
      rsp_free   <= free_count_next;
    end
  end

  assign rsp_ch.valid        = rsp_valid;
  assign rsp_ch.status       = rsp_status;
  assign rsp_ch.granted_page = rsp_grant;
  assign rsp_ch.free_pages   = rsp_free;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `FPFL_ASSERT(a_stack_within_free, stacked <= free_count, "stack deeper than free count")
  `FPFL_ASSERT(a_free_within_cap, free_count <= PAGE_CAP, "free count above capacity")
  `FPFL_ASSERT(a_rsp_from_exec, $rose(rsp_valid) |-> $past(state) == S_EXEC, "stray response")
  `FPFL_ASSERT(a_exec_rsp_free, exec |-> !rsp_valid || rsp_ch.ready, "response overwritten")
  `FPFL_ASSERT(a_grant_only_ok, rsp_valid && rsp_status != ST_OK |-> rsp_grant == '0, "bad grant")
  `FPFL_ASSERT_ALWAYS(a_no_write_outside_exec, link_we |-> exec, "link write outside execute")

endmodule
